// ===== rtl/srf_pkg.sv =====
// Shared types, codes and helpers for the serial register access framer.
// No dependencies; the front, queue, back and top import this package.
package srf_pkg;

	// Input item actions
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_RX    = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_TX    = 2'd0;
	localparam logic [1:0] KIND_WDONE = 2'd1;
	localparam logic [1:0] KIND_RDONE = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_HEADER = 2'd0;
	localparam logic [1:0] CFG_OPCODE = 2'd1;
	localparam logic [1:0] CFG_ACK    = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_WACK = 3'b010,
		PH_READ = 3'b100
	} phase_t;

	typedef enum logic [1:0] {
		JOB_WFRAME = 2'd0,
		JOB_RFRAME = 2'd1,
		JOB_WDONE  = 2'd2,
		JOB_RDONE  = 2'd3
	} job_kind_t;

	// Work handed from the front to the back through the queue
	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  addr;
		logic [1:0]  len;
		logic [23:0] wval;
		logic        ack_ok;
		logic [23:0] rdata;
	} job_t;

	typedef struct packed {
		logic idle;
		logic push;
	} front_stat_t;

	// Sign-extend a little-endian value of len bytes to 24 bits
	function automatic logic [23:0] sext_value(input logic [23:0] acc, input logic [1:0] len);
		logic [23:0] v;
		begin
			case (len)
				2'd0: v = 24'd0;
				2'd1: v = {{16{acc[7]}}, acc[7:0]};
				2'd2: v = {{8{acc[15]}}, acc[15:0]};
				2'd3: v = acc;
				default: v = 24'd0;
			endcase
			return v;
		end
	endfunction

endpackage

// ===== rtl/srf_if.sv =====
// Valid/ready channel interfaces for the request item and the result item.
// Depends on nothing; used by the front, the back and the top level.
interface srf_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  reg_address;
	logic [1:0]  reg_length;
	logic [23:0] write_value;
	logic [7:0]  rx_byte;

	modport source(output valid, action, reg_address, reg_length, write_value, rx_byte,
		input ready);
	modport sink(input valid, action, reg_address, reg_length, write_value, rx_byte,
		output ready);
endinterface

interface srf_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [7:0]         tx_byte;
	logic               frame_end;
	logic               ack_ok;
	logic signed [23:0] read_value;

	modport source(output valid, kind, tx_byte, frame_end, ack_ok, read_value, input ready);
	modport sink(input valid, kind, tx_byte, frame_end, ack_ok, read_value, output ready);
endinterface

// ===== rtl/srf_front.sv =====
// Front end: accepts requests and received bytes, tracks the reply phase,
// and pushes frame or completion jobs into the queue. Depends on srf_pkg.
module srf_front import srf_pkg::*; #(
	parameter int MAX_REG_BYTES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	srf_in_if.sink      item,
	input  logic [7:0]  ack_byte,
	input  logic        q_full,
	output job_t        q_job,
	output front_stat_t stat
);

	localparam logic [2:0] MaxLen = 3'(MAX_REG_BYTES);

	phase_t      phase_q;
	logic [2:0]  expect_q;
	logic [2:0]  seen_q;
	logic [1:0]  plen_q;
	logic [23:0] acc_q;
	logic        match_q;

	logic        take;
	logic [1:0]  len_c;
	logic [2:0]  seen_n;
	logic        match_n;
	logic [23:0] acc_n;
	logic        done;

	assign item.ready = !q_full;
	assign take = item.valid && !q_full;

	assign len_c = ({1'b0, item.reg_length} > MaxLen) ? MaxLen[1:0] : item.reg_length;
	assign seen_n = seen_q + 3'd1;
	assign match_n = match_q && (item.rx_byte == ack_byte);
	assign done = (seen_n >= expect_q);

	always_comb begin
		acc_n = acc_q;
		if (seen_q >= 3'd1 && seen_q <= {1'b0, plen_q})
			acc_n = acc_q | (24'(item.rx_byte) << {seen_q - 3'd1, 3'b000});
	end

	always_comb begin
		q_job = '{kind: JOB_WFRAME, addr: item.reg_address, len: len_c,
			wval: item.write_value, ack_ok: match_n, rdata: sext_value(acc_n, plen_q)};
		stat.idle = (phase_q == PH_IDLE);
		stat.push = 1'b0;
		if (take) begin
			case (phase_q)
				PH_IDLE: begin
					if (item.action == ACT_WRITE) begin
						q_job.kind = JOB_WFRAME;
						stat.push = 1'b1;
					end else if (item.action == ACT_READ) begin
						q_job.kind = JOB_RFRAME;
						stat.push = 1'b1;
					end
				end
				PH_WACK: begin
					q_job.kind = JOB_WDONE;
					stat.push = (item.action == ACT_RX) && done;
				end
				PH_READ: begin
					q_job.kind = JOB_RDONE;
					stat.push = (item.action == ACT_RX) && done;
				end
				default: stat.push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			expect_q <= '0;
			seen_q   <= '0;
			plen_q   <= '0;
			acc_q    <= '0;
			match_q  <= 1'b1;
		end else if (take) begin
			case (phase_q)
				PH_IDLE: begin
					if (item.action == ACT_WRITE || item.action == ACT_READ) begin
						phase_q  <= (item.action == ACT_WRITE) ? PH_WACK : PH_READ;
						expect_q <= (item.action == ACT_WRITE) ? 3'd2 : {1'b0, len_c} + 3'd2;
						seen_q   <= '0;
						plen_q   <= len_c;
						acc_q    <= '0;
						match_q  <= 1'b1;
					end
				end
				PH_WACK: begin
					if (item.action == ACT_RX) begin
						match_q <= match_n;
						seen_q  <= done ? 3'd0 : seen_n;
						if (done)
							phase_q <= PH_IDLE;
					end
				end
				PH_READ: begin
					if (item.action == ACT_RX) begin
						acc_q  <= acc_n;
						seen_q <= done ? 3'd0 : seen_n;
						if (done)
							phase_q <= PH_IDLE;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/srf_queue.sv =====
// Two-entry job queue between the front and the back.
// Depends on srf_pkg for the job type.
module srf_queue import srf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  job_t       push_job,
	input  logic       pop,
	output job_t       head,
	output logic       empty,
	output logic       full,
	output logic [1:0] level
);

	job_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;

	assign head  = mem_q[rptr_q];
	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);
	assign level = count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wptr_q <= !wptr_q;
			if (pop)
				rptr_q <= !rptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== rtl/srf_back.sv =====
// Back end: puts frame jobs byte by byte and completion jobs whole into
// the output register. Depends on srf_pkg and the result interface.
module srf_back import srf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       job,
	input  logic       q_empty,
	input  logic [7:0] header_byte,
	input  logic [7:0] read_opcode,
	output logic       pop,
	srf_out_if.source  result
);

	logic [2:0] idx_q;
	logic       load;
	logic       fire;
	logic [2:0] count;
	logic       last;
	logic [7:0] vb0, vb1, vb2;
	logic [7:0] wsum, rsum;
	logic [7:0] byte_c;
	logic [1:0] kind_c;
	logic [2:0] vsel;

	assign load = !result.valid || result.ready;
	assign fire = !q_empty && load;

	assign vb0  = (job.len >= 2'd1) ? job.wval[7:0] : 8'd0;
	assign vb1  = (job.len >= 2'd2) ? job.wval[15:8] : 8'd0;
	assign vb2  = (job.len >= 2'd3) ? job.wval[23:16] : 8'd0;
	assign wsum = {6'd0, job.len} + 8'd1 + job.addr + vb0 + vb1 + vb2;
	assign rsum = read_opcode + job.addr + {6'd0, job.len};
	assign vsel = idx_q - 3'd3;

	always_comb begin
		byte_c = 8'd0;
		kind_c = KIND_TX;
		count  = 3'd1;
		case (job.kind)
			JOB_WFRAME: begin
				count = {1'b0, job.len} + 3'd4;
				case (idx_q)
					3'd0: byte_c = header_byte;
					3'd1: byte_c = {6'd0, job.len} + 8'd1;
					3'd2: byte_c = job.addr;
					default: begin
						if (idx_q < {1'b0, job.len} + 3'd3)
							byte_c = 8'(job.wval >> {vsel[1:0], 3'b000});
						else
							byte_c = wsum;
					end
				endcase
			end
			JOB_RFRAME: begin
				count = 3'd5;
				case (idx_q)
					3'd0: byte_c = header_byte;
					3'd1: byte_c = read_opcode;
					3'd2: byte_c = job.addr;
					3'd3: byte_c = {6'd0, job.len};
					default: byte_c = rsum;
				endcase
			end
			JOB_WDONE: kind_c = KIND_WDONE;
			JOB_RDONE: kind_c = KIND_RDONE;
			default: kind_c = KIND_TX;
		endcase
	end

	assign last = (idx_q == count - 3'd1);
	assign pop  = fire && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
			idx_q        <= '0;
		end else if (load) begin
			result.valid <= !q_empty;
			if (fire)
				idx_q <= last ? 3'd0 : idx_q + 3'd1;
		end
	end

	// Payload holds while the receiver stalls
	always_ff @(posedge clk) begin
		if (fire) begin
			result.kind       <= kind_c;
			result.tx_byte    <= byte_c;
			result.frame_end  <= (kind_c == KIND_TX) && last;
			result.ack_ok     <= (job.kind == JOB_WDONE) && job.ack_ok;
			result.read_value <= (job.kind == JOB_RDONE) ? job.rdata : 24'd0;
		end
	end

endmodule

// ===== rtl/serial_register_access_framer.sv =====
// Serial register access framer: host side of a byte-serial register protocol.
// Channels: item (sink) takes write requests, read requests and received
// device bytes; result (source) gives transmit bytes of request frames, with
// frame_end on the last one, and write/read completions (ack_ok, read_value).
// Configuration: cfg_we/cfg_index/cfg_data write header_byte, read_opcode
// and ack_byte; write them only while no request is in flight.
// An accepted job is queued first; its results then enter the output register.
// Throughput: one item per cycle while the two-entry job queue has room; the
// result register emits one byte per cycle while the receiver is ready; a
// request frame has 4 + length bytes (write) or 5 bytes (read), and the
// queue fills when the receiver is slower than the requests.
// Bytes received while idle, requests while a reply is awaited and action 3
// are taken and dropped. When the receiver stalls, the result holds and the
// queue absorbs up to two jobs before item.ready falls.
// Reset sets idle phase, empty queue, no valid result and configuration 0.
// Depends on srf_pkg, srf_if, srf_front, srf_queue and srf_back.
module serial_register_access_framer import srf_pkg::*; #(
	parameter int MAX_REG_BYTES = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	srf_in_if.sink     item,
	srf_out_if.source  result,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0]  header_q;
	logic [7:0]  opcode_q;
	logic [7:0]  ack_q;

	job_t        push_job;
	job_t        head;
	front_stat_t fstat;
	logic        q_empty;
	logic        q_full;
	logic [1:0]  q_level;
	logic        q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= '0;
			opcode_q <= '0;
			ack_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEADER: header_q <= cfg_data;
				CFG_OPCODE: opcode_q <= cfg_data;
				CFG_ACK:    ack_q    <= cfg_data;
				default:    ack_q    <= ack_q;
			endcase
		end
	end

	srf_front #(.MAX_REG_BYTES(MAX_REG_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n), .item(item), .ack_byte(ack_q),
		.q_full(q_full), .q_job(push_job), .stat(fstat)
	);

	srf_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(fstat.push), .push_job(push_job),
		.pop(q_pop), .head(head), .empty(q_empty), .full(q_full), .level(q_level)
	);

	srf_back u_back (
		.clk(clk), .arst_n(arst_n), .job(head), .q_empty(q_empty),
		.header_byte(header_q), .read_opcode(opcode_q), .pop(q_pop), .result(result)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.push |-> q_level != 2'd2)
		else $error("job pushed into a full queue");

	a_read_queued: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready && item.action == ACT_READ && fstat.idle
		|=> q_level != 2'd0)
		else $error("read request left no job");

	a_end_on_tx: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.frame_end |-> result.kind == KIND_TX)
		else $error("frame_end on a completion result");

	a_pop_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty ##1 result.valid)
		else $error("finished job not presented");

endmodule
